FILE: hw/rtl/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// shared widths, register codes, pipeline types and saturating arithmetic
// for the sgd momentum update datapath
// ----------------------------------------------------------------------------
package sgdm_pkg;

  // value and coefficient formats
  localparam int DATA_W    = 32;                   // signed q16.16 values
  localparam int COEF_W    = 18;                   // unsigned q2.16 coefficients
  localparam int COEF_FRAC = 16;                   // coefficient scale sets the shift
  localparam int PROD_W    = DATA_W + COEF_W;      // exact magnitude product
  localparam int RND_W     = PROD_W - COEF_FRAC;   // product after rounding shift

  // stream widths
  localparam int IN_TDATA_W  = 4 * DATA_W;
  localparam int OUT_TDATA_W = 2 * DATA_W;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = COEF_W;

  localparam logic [CFG_INDEX_W-1:0] REG_NESTEROV_MODE   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE   = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM_FACTOR = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_DECAY    = CFG_INDEX_W'(3);

  // saturation bounds
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

  // magnitude limits after rounding: negative side reaches one further
  localparam logic [RND_W-1:0] LIM_NEG = RND_W'(1) << (DATA_W - 1);
  localparam logic [RND_W-1:0] LIM_POS = LIM_NEG - RND_W'(1);

  // half an lsb of the shifted product, for round to nearest
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC - 1);

  typedef struct packed {
    logic              nesterov;
    logic [COEF_W-1:0] lr;
    logic [COEF_W-1:0] mu;
    logic [COEF_W-1:0] wd;
  } cfg_t;

  // one item as it travels down the pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              sat;
    logic [DATA_W-1:0] tgt;
    logic [DATA_W-1:0] gi;
    logic [DATA_W-1:0] vel;
    logic [DATA_W-1:0] aux;
  } lane_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat_val_t;

  function automatic sat_val_t sat_add(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    logic [DATA_W:0] sum;
    sat_val_t        r;
    sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      r.sat = 1'b1;
      r.val = sum[DATA_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = sum[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_val_t sat_sub(input logic [DATA_W-1:0] a,
                                       input logic [DATA_W-1:0] b);
    logic [DATA_W:0] diff;
    sat_val_t        r;
    diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (diff[DATA_W] != diff[DATA_W-1]) begin
      r.sat = 1'b1;
      r.val = diff[DATA_W] ? VAL_MIN : VAL_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = diff[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/sgd_momentum_update.sv
// ----------------------------------------------------------------------------
// sgd_momentum_update
// element-wise sgd step with momentum, classic or nesterov look-ahead
// ----------------------------------------------------------------------------
// Each item carries a parameter x, its gradient g, the old velocity and the
// old target, all signed q16.16. The block computes g' = g + wd*x,
// v = mu*v_in + g', and t = t_in - lr*v (classic) or
// t = t_in - lr*(mu*v + g') (nesterov). Products with the q2.16 coefficients
// round to nearest, ties away from zero; every product and sum saturates and
// any clip raises the saturated flag of that item. The datapath is a ten
// register pipeline built around four 32x18 magnitude multipliers of two
// stages each, so a new item is taken every clock while the result side is
// not stalled, and its result moves through s1_r to s9_r into the output
// register. A stall on the result side freezes the whole pipeline in place;
// in_tready follows out_tready through the output register.
// The user must write configuration via the cfg port (always ready) only while
// no items are in flight (the block does not check); unknown index writes drop.
// ----------------------------------------------------------------------------
module sgd_momentum_update (
  input  logic                                  clk,
  input  logic                                  rst_n,

  // input items
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [31:0] param_value, [63:32] gradient, [95:64] velocity_in, [127:96] target_in
  input  logic [sgdm_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  in_tlast,     // last_in

  // result items
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [31:0] velocity_out, [63:32] target_out
  output logic [sgdm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [0] saturated
  output logic                                  out_tuser,
  output logic                                  out_tlast,    // last_out

  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sgdm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sgdm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DW = sgdm_pkg::DATA_W;

  sgdm_pkg::cfg_t cfg;

  // pipeline advance: everything moves unless the output holds an untaken item
  logic adv;

  sgdm_pkg::lane_t s0;
  sgdm_pkg::lane_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, out_r;
  sgdm_pkg::lane_t s3_nxt, s4_nxt, s7_nxt, out_nxt;

  // multiplier results, each aligned with the stage register noted
  logic [DW-1:0] wd_term, mv_term, c_term, d_term;   // s2, s2, s6, s9
  logic          wd_sat, mv_sat, c_sat, d_sat;
  logic [sgdm_pkg::COEF_W-1:0] c_coef;

  sgdm_pkg::sat_val_t sa, sb, sc, sd;
  logic [DW-1:0]      step;

  assign cfg_ready = 1'b1;

  sgdm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv       = !out_r.vld || out_tready;
  assign in_tready = adv;

  // stage 0: unpack the incoming item
  always_comb begin
    s0      = '0;
    s0.vld  = in_tvalid;
    s0.last = in_tlast;
    s0.gi   = in_tdata[2*DW-1:DW];
    s0.tgt  = in_tdata[4*DW-1:3*DW];
  end

  // stages 1-2: decay product and momentum product side by side
  sgdm_coef_mul u_mul_wd (
    .clk      (clk),
    .en       (adv),
    .value_i  (in_tdata[DW-1:0]),
    .coef_i   (cfg.wd),
    .result_o (wd_term),
    .sat_o    (wd_sat)
  );

  sgdm_coef_mul u_mul_mv (
    .clk      (clk),
    .en       (adv),
    .value_i  (in_tdata[3*DW-1:2*DW]),
    .coef_i   (cfg.mu),
    .result_o (mv_term),
    .sat_o    (mv_sat)
  );

  // stage 3: decayed gradient g' (a zero coefficient gives a zero term)
  always_comb begin
    sa         = sgdm_pkg::sat_add(s2_r.gi, wd_term);
    s3_nxt     = s2_r;
    s3_nxt.gi  = sa.val;
    s3_nxt.aux = mv_term;
    s3_nxt.sat = s2_r.sat | wd_sat | mv_sat | sa.sat;
  end

  // stage 4: new velocity
  always_comb begin
    sb         = sgdm_pkg::sat_add(s3_r.aux, s3_r.gi);
    s4_nxt     = s3_r;
    s4_nxt.vel = sb.val;
    s4_nxt.sat = s3_r.sat | sb.sat;
  end

  // stages 5-6: classic takes lr*v as the step, nesterov forms mu*v
  assign c_coef = cfg.nesterov ? cfg.mu : cfg.lr;

  sgdm_coef_mul u_mul_c (
    .clk      (clk),
    .en       (adv),
    .value_i  (s4_r.vel),
    .coef_i   (c_coef),
    .result_o (c_term),
    .sat_o    (c_sat)
  );

  // stage 7: look-ahead sum in nesterov mode, else hold the classic step
  always_comb begin
    sc         = sgdm_pkg::sat_add(c_term, s6_r.gi);
    s7_nxt     = s6_r;
    s7_nxt.aux = cfg.nesterov ? sc.val : c_term;
    s7_nxt.sat = s6_r.sat | c_sat | (cfg.nesterov & sc.sat);
  end

  // stages 8-9: lr times look-ahead, only used in nesterov mode
  sgdm_coef_mul u_mul_d (
    .clk      (clk),
    .en       (adv),
    .value_i  (s7_r.aux),
    .coef_i   (cfg.lr),
    .result_o (d_term),
    .sat_o    (d_sat)
  );

  // stage 10: target update into the output register
  always_comb begin
    step        = cfg.nesterov ? d_term : s9_r.aux;
    sd          = sgdm_pkg::sat_sub(s9_r.tgt, step);
    out_nxt     = s9_r;
    out_nxt.tgt = sd.val;
    out_nxt.sat = s9_r.sat | (cfg.nesterov & d_sat) | sd.sat;
  end

  // valid bits reset, payload just follows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      s2_r.vld  <= 1'b0;
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      s5_r.vld  <= 1'b0;
      s6_r.vld  <= 1'b0;
      s7_r.vld  <= 1'b0;
      s8_r.vld  <= 1'b0;
      s9_r.vld  <= 1'b0;
      out_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r  <= s0;
      s2_r  <= s1_r;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      s5_r  <= s4_r;
      s6_r  <= s5_r;
      s7_r  <= s7_nxt;
      s8_r  <= s7_r;
      s9_r  <= s8_r;
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_r.vld;
  assign out_tdata  = {out_r.tgt, out_r.vel};
  assign out_tuser  = out_r.sat;
  assign out_tlast  = out_r.last;

endmodule

FILE: hw/rtl/sgdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sgdm_cfg_regs
// configuration registers: mode bit and three q2.16 coefficients
// ----------------------------------------------------------------------------
module sgdm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [sgdm_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [sgdm_pkg::CFG_DATA_W-1:0]    wr_data,
  output sgdm_pkg::cfg_t                     cfg
);

  sgdm_pkg::cfg_t cfg_r;
  sgdm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        sgdm_pkg::REG_NESTEROV_MODE:   cfg_nxt.nesterov = wr_data[0];
        sgdm_pkg::REG_LEARNING_RATE:   cfg_nxt.lr       = wr_data;
        sgdm_pkg::REG_MOMENTUM_FACTOR: cfg_nxt.mu       = wr_data;
        sgdm_pkg::REG_WEIGHT_DECAY:    cfg_nxt.wd       = wr_data;
        default:                       cfg_nxt          = cfg_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/sgdm_coef_mul.sv
// ----------------------------------------------------------------------------
// sgdm_coef_mul
// two-stage value times coefficient: magnitude multiply, then round to
// nearest (ties away from zero), clip and restore the sign
// ----------------------------------------------------------------------------
module sgdm_coef_mul (
  input  logic                            clk,
  input  logic                            en,
  input  logic [sgdm_pkg::DATA_W-1:0]     value_i,
  input  logic [sgdm_pkg::COEF_W-1:0]     coef_i,
  output logic [sgdm_pkg::DATA_W-1:0]     result_o,
  output logic                            sat_o
);

  logic                          neg_r;
  logic                          neg_nxt;
  logic [sgdm_pkg::PROD_W-1:0]   prod_r;
  logic [sgdm_pkg::PROD_W-1:0]   prod_nxt;
  logic [sgdm_pkg::DATA_W-1:0]   mag;

  logic [sgdm_pkg::DATA_W-1:0]   result_r;
  logic [sgdm_pkg::DATA_W-1:0]   result_nxt;
  logic                          sat_r;
  logic                          sat_nxt;
  logic [sgdm_pkg::PROD_W-1:0]   rnd_full;
  logic [sgdm_pkg::RND_W-1:0]    rnd;
  logic [sgdm_pkg::RND_W-1:0]    lim;
  logic [sgdm_pkg::DATA_W-1:0]   mag_clip;

  // stage a: magnitude product, exact
  always_comb begin
    neg_nxt  = value_i[sgdm_pkg::DATA_W-1];
    mag      = neg_nxt ? (~value_i + sgdm_pkg::DATA_W'(1)) : value_i;
    prod_nxt = sgdm_pkg::PROD_W'(mag) * sgdm_pkg::PROD_W'(coef_i);
  end

  // stage b: round, clip to the side's limit, negate back
  always_comb begin
    rnd_full = prod_r + sgdm_pkg::RND_HALF;
    rnd      = rnd_full[sgdm_pkg::PROD_W-1:sgdm_pkg::COEF_FRAC];
    lim      = neg_r ? sgdm_pkg::LIM_NEG : sgdm_pkg::LIM_POS;
    if (rnd > lim) begin
      sat_nxt  = 1'b1;
      mag_clip = lim[sgdm_pkg::DATA_W-1:0];
    end else begin
      sat_nxt  = 1'b0;
      mag_clip = rnd[sgdm_pkg::DATA_W-1:0];
    end
    result_nxt = neg_r ? (~mag_clip + sgdm_pkg::DATA_W'(1)) : mag_clip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r    <= neg_nxt;
      prod_r   <= prod_nxt;
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign result_o = result_r;
  assign sat_o    = sat_r;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stream-level check of the sgd momentum update block: a scoreboard predicts
// velocity, target and clip flag per item and compares them in order, while
// tasks drive directed corner items and random items under random idling
// ----------------------------------------------------------------------------
module tb;
  import sgdm_pkg::*;

  // signed range of a value, widened for exact intermediate arithmetic
  localparam longint VAL_HI = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint VAL_LO = -VAL_HI - 1;

  // coefficient extremes and handy points
  localparam logic [COEF_W-1:0] COEF_MAX  = '1;
  localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC;
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1) << (COEF_FRAC - 1);
  localparam logic [COEF_W-1:0] COEF_0P9  = COEF_W'(58982);

  // register indexes the block does not implement
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_INDEX    = '1;

  localparam int RAND_BLOCKS    = 8;
  localparam int BLOCK_ITEMS    = 135;
  localparam int DRAIN_CYCLES   = 20;    // longer than the ten-stage pipeline

  typedef struct packed {
    logic [DATA_W-1:0] x;     // parameter
    logic [DATA_W-1:0] g;     // gradient
    logic [DATA_W-1:0] v;     // old velocity
    logic [DATA_W-1:0] t;     // old target
    logic              last;
  } elem_t;

  typedef struct packed {
    logic [DATA_W-1:0] vel;
    logic [DATA_W-1:0] tgt;
    logic              sat;
    logic              last;
  } update_t;

  // --------------------------------------------------------------------------
  // scoreboard: register mirror, update predictor and in-order result check
  // --------------------------------------------------------------------------
  class sgdm_scoreboard;
    cfg_t        regs = '0;
    update_t     expected_updates[$];
    int unsigned errors = 0;
    bit          clipped;

    function void mirror_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NESTEROV_MODE:   regs.nesterov = data[0];
        REG_LEARNING_RATE:   regs.lr = data;
        REG_MOMENTUM_FACTOR: regs.mu = data;
        REG_WEIGHT_DECAY:    regs.wd = data;
        default: ;
      endcase
    endfunction

    function longint clip(longint s);
      if (s > VAL_HI) begin
        clipped = 1'b1;
        return VAL_HI;
      end
      if (s < VAL_LO) begin
        clipped = 1'b1;
        return VAL_LO;
      end
      return s;
    endfunction

    // value times q2.16 coefficient, rounded half away from zero on the magnitude
    function longint scale_coef(longint v, logic [COEF_W-1:0] c);
      longint unsigned mag;
      longint unsigned r;
      longint unsigned lim;
      mag = (v < 0) ? -v : v;
      r   = (mag * c + (64'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
      lim = (v < 0) ? VAL_HI + 1 : VAL_HI;
      if (r > lim) begin
        clipped = 1'b1;
        r = lim;
      end
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function update_t step_element(elem_t e);
      longint  x, g, v_old, t_old, gi, v, stride, t;
      update_t u;
      clipped = 1'b0;
      x     = longint'($signed(e.x));
      g     = longint'($signed(e.g));
      v_old = longint'($signed(e.v));
      t_old = longint'($signed(e.t));
      gi = g;
      if (regs.wd != '0)
        gi = clip(g + scale_coef(x, regs.wd));
      v = clip(scale_coef(v_old, regs.mu) + gi);
      if (regs.nesterov)
        stride = scale_coef(clip(scale_coef(v, regs.mu) + gi), regs.lr);
      else
        stride = scale_coef(v, regs.lr);
      t = clip(t_old - stride);
      u.vel  = v[DATA_W-1:0];
      u.tgt  = t[DATA_W-1:0];
      u.sat  = clipped;
      u.last = e.last;
      return u;
    endfunction

    function void note_element(elem_t e);
      expected_updates.push_back(step_element(e));
    endfunction

    function void check_update(logic [OUT_TDATA_W-1:0] tdata, logic tuser, logic tlast);
      update_t want;
      if (expected_updates.size() == 0) begin
        $display("%0t unexpected result: got data %h flag %b last %b",
                 $time, tdata, tuser, tlast);
        errors++;
        return;
      end
      want = expected_updates.pop_front();
      if (tdata[DATA_W-1:0] !== want.vel) begin
        $display("%0t velocity_out mismatch: expected %h, got %h",
                 $time, want.vel, tdata[DATA_W-1:0]);
        errors++;
      end
      if (tdata[2*DATA_W-1:DATA_W] !== want.tgt) begin
        $display("%0t target_out mismatch: expected %h, got %h",
                 $time, want.tgt, tdata[2*DATA_W-1:DATA_W]);
        errors++;
      end
      if (tuser !== want.sat) begin
        $display("%0t saturated mismatch: expected %b, got %b", $time, want.sat, tuser);
        errors++;
      end
      if (tlast !== want.last) begin
        $display("%0t last_out mismatch: expected %b, got %b", $time, want.last, tlast);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned send_idle_pct = 0;    // chance of a gap before each item
  int unsigned recv_stall_pct = 0;   // chance of out_tready low per cycle

  sgdm_scoreboard board = new;

  always #6 clk = ~clk;

  sgd_momentum_update u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // result side: check every accepted item, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      board.check_update(out_tdata, out_tuser, out_tlast);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // leaves cfg_valid high so back-to-back writes never toggle it within a step
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.mirror_reg(idx, data);
  endtask

  task automatic apply_settings(logic nest, logic [COEF_W-1:0] lr, logic [COEF_W-1:0] mu,
                                logic [COEF_W-1:0] wd);
    write_reg(REG_NESTEROV_MODE, CFG_DATA_W'(nest));
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_MOMENTUM_FACTOR, mu);
    write_reg(REG_WEIGHT_DECAY, wd);
    cfg_valid <= 1'b0;
  endtask

  // valid stays high into the next item unless a gap is drawn
  task automatic send_element(elem_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {e.t, e.v, e.g, e.x};
    in_tlast  <= e.last;
    do @(posedge clk); while (!in_tready);
    board.note_element(e);
  endtask

  // all results back means the pipeline is empty, so registers may change
  task automatic wait_idle();
    while (board.expected_updates.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_idling(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  function automatic elem_t make_elem(logic [DATA_W-1:0] x, logic [DATA_W-1:0] g,
                                      logic [DATA_W-1:0] v, logic [DATA_W-1:0] t,
                                      logic last);
    elem_t e;
    e.x = x;
    e.g = g;
    e.v = v;
    e.t = t;
    e.last = last;
    return e;
  endfunction

  // mostly moderate q16.16 values so that not every result clips
  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return r;
      1: begin
        case ($urandom_range(4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          3: return '1;
          default: return DATA_W'(1);
        endcase
      end
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return '0;
      1: return COEF_MAX;
      2: return COEF_ONE;
      default: return COEF_W'($urandom_range(0, (1 << COEF_W) - 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero coefficients, so velocity is the gradient and the
    // target passes through
    set_idling(0);
    send_element(make_elem(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, 1'b1));
    send_element(make_elem(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MIN, 1'b0));
    in_tvalid <= 1'b0;
    wait_idle();

    // largest coefficients, classic: clipping on every path
    apply_settings(1'b0, COEF_MAX, COEF_MAX, COEF_MAX);
    send_element(make_elem(VAL_MAX, VAL_MAX, VAL_MAX, '0, 1'b0));
    send_element(make_elem(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, 1'b1));
    send_element(make_elem('0, '0, '0, '0, 1'b0));
    send_element(make_elem('1, DATA_W'(1), '1, DATA_W'(1), 1'b0));
    in_tvalid <= 1'b0;
    wait_idle();

    // only the low bit of the mode write is kept, so this stays classic;
    // writes to unimplemented indexes must change nothing
    write_reg(REG_NESTEROV_MODE, CFG_DATA_W'(2));
    write_reg(REG_FIRST_UNUSED, '1);
    write_reg(REG_TOP_INDEX, '0);
    write_reg(REG_LEARNING_RATE, COEF_ONE);
    write_reg(REG_MOMENTUM_FACTOR, COEF_HALF);
    write_reg(REG_WEIGHT_DECAY, '0);
    cfg_valid <= 1'b0;
    // decay disabled: huge parameter adds nothing and raises no flag;
    // half-momentum exposes rounding ties on both signs
    send_element(make_elem(VAL_MAX, '0, DATA_W'(1), '0, 1'b0));
    send_element(make_elem(VAL_MIN, '0, '1, '0, 1'b1));
    send_element(make_elem('0, '0, DATA_W'(3), '0, 1'b0));
    send_element(make_elem('0, '0, -DATA_W'(3), '0, 1'b0));
    in_tvalid <= 1'b0;
    wait_idle();

    // nesterov via an odd data word, smallest nonzero decay
    write_reg(REG_NESTEROV_MODE, CFG_DATA_W'(3));
    write_reg(REG_LEARNING_RATE, COEF_0P9);
    write_reg(REG_MOMENTUM_FACTOR, COEF_0P9);
    write_reg(REG_WEIGHT_DECAY, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    send_element(make_elem(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, 1'b1));
    send_element(make_elem(32'h0001_0000, 32'hffff_8000, 32'h0002_0000, 32'h0010_0000, 1'b0));
    send_element(make_elem(VAL_MIN, 32'h0000_4000, 32'hfffe_0000, VAL_MAX, 1'b0));
    send_element(make_elem('1, '1, '1, '1, 1'b1));
    in_tvalid <= 1'b0;
    wait_idle();

    // nesterov with the largest coefficients
    apply_settings(1'b1, COEF_MAX, COEF_MAX, COEF_MAX);
    send_element(make_elem(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 1'b0));
    send_element(make_elem(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 1'b0));
    send_element(make_elem(32'h0000_1234, DATA_W'(1), '0, '0, 1'b1));
    in_tvalid <= 1'b0;
    wait_idle();

    // random blocks, each with fresh settings and one idling phase
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      if ($urandom_range(2) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(4, (1 << CFG_INDEX_W) - 1)),
                  CFG_DATA_W'($urandom));
      apply_settings(1'($urandom_range(1)), rand_coef(), rand_coef(), rand_coef());
      set_idling(blk % 4);
      for (int n = 0; n < BLOCK_ITEMS; n++)
        send_element(make_elem(rand_value(), rand_value(), rand_value(), rand_value(),
                               $urandom_range(15) == 0));
      in_tvalid <= 1'b0;
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
